>>> sv/hcbd_pkg.sv
package hcbd_pkg;

  localparam int unsigned HCBD_SIZE_BITS = 64;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef logic [HCBD_SIZE_BITS-1:0] size_t;

  typedef enum logic [3:0] {
    PH_WS       = 4'd0,
    PH_SIGN     = 4'd1,
    PH_ZERO     = 4'd2,
    PH_X        = 4'd3,
    PH_DIGITS   = 4'd4,
    PH_LINE     = 4'd5,
    PH_LINE_CR  = 4'd6,
    PH_DATA     = 4'd7,
    PH_TRAIL    = 4'd8,
    PH_TRAIL_CR = 4'd9,
    PH_DONE     = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    ST_TERMINATED = 2'd0,
    ST_NO_ZERO    = 2'd1,
    ST_TRUNCATED  = 2'd2,
    ST_MALFORMED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       body_end;
    logic [1:0] end_status;
  } res_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_F));
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      v = c - CH_ZERO;
    end else if ((c >= CH_LC_A) && (c <= CH_LC_F)) begin
      v = c - CH_LC_A + 8'd10;
    end else begin
      v = c - CH_UC_A + 8'd10;
    end
    return v[3:0];
  endfunction

  // Appends one hex digit; the count saturates once it would overflow.
  function automatic size_t add_digit(size_t cur, logic [3:0] d);
    if (cur[HCBD_SIZE_BITS-1 -: 4] != 4'd0) begin
      return '1;
    end
    return {cur[HCBD_SIZE_BITS-5:0], d};
  endfunction

endpackage

>>> sv/hcbd_ifs.sv
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_final;

  modport source (output valid, output in_byte, output in_final, input ready);
  modport sink (input valid, input in_byte, input in_final, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       body_end;
  logic [1:0] end_status;

  modport source (output valid, output out_byte, output byte_valid, output body_end,
                  output end_status, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input body_end,
                input end_status, output ready);
endinterface

>>> sv/hcbd_parser.sv
module hcbd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_final,
  output hcbd_pkg::res_t res,
  output logic          has_res
);
  import hcbd_pkg::*;

  phase_t  phase_r, phase_nxt, size_ph;
  size_t   left_r, left_nxt;
  logic    neg_r, neg_nxt;
  status_t sticky_r, sticky_nxt, status;
  logic    emit, do_size, hex;
  logic [3:0] digit;

  assign hex   = is_hex(in_byte);
  assign digit = hex_val(in_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WS;
      left_r   <= '0;
      neg_r    <= 1'b0;
      sticky_r <= ST_TERMINATED;
    end else if (accept) begin
      if (in_final) begin
        phase_r  <= PH_WS;
        left_r   <= '0;
        neg_r    <= 1'b0;
        sticky_r <= ST_TERMINATED;
      end else begin
        phase_r  <= phase_nxt;
        left_r   <= left_nxt;
        neg_r    <= neg_nxt;
        sticky_r <= sticky_nxt;
      end
    end
  end

  always_comb begin : next_state
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    neg_nxt    = neg_r;
    sticky_nxt = sticky_r;
    emit       = 1'b0;
    do_size    = 1'b0;
    size_ph    = PH_WS;
    unique case (phase_r)
      PH_DONE: begin
      end
      PH_DATA: begin
        emit     = 1'b1;
        left_nxt = left_r - size_t'(1);
        if (left_r == size_t'(1)) begin
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (in_byte == CH_CR) begin
          phase_nxt = PH_TRAIL_CR;
        end else begin
          do_size = 1'b1;
        end
      end
      PH_TRAIL_CR: begin
        phase_nxt = PH_WS;
        do_size   = (in_byte != CH_LF);
      end
      PH_WS, PH_SIGN, PH_ZERO, PH_X, PH_DIGITS, PH_LINE, PH_LINE_CR: begin
        do_size = 1'b1;
        size_ph = phase_r;
      end
      default: begin
        do_size = 1'b1;
      end
    endcase

    if (do_size) begin
      if (size_ph == PH_WS) begin
        phase_nxt = PH_WS;
        if (!is_space(in_byte)) begin
          left_nxt = '0;
          neg_nxt  = 1'b0;
          if ((in_byte == CH_PLUS) || (in_byte == CH_MINUS)) begin
            neg_nxt   = (in_byte == CH_MINUS);
            phase_nxt = PH_SIGN;
          end else if (in_byte == CH_ZERO) begin
            phase_nxt = PH_ZERO;
          end else if (hex) begin
            left_nxt  = add_digit('0, digit);
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt  = PH_DONE;
            sticky_nxt = ST_MALFORMED;
          end
        end
      end else if (size_ph == PH_SIGN) begin
        if (in_byte == CH_ZERO) begin
          phase_nxt = PH_ZERO;
        end else if (hex) begin
          left_nxt  = add_digit(left_r, digit);
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt  = PH_DONE;
          sticky_nxt = ST_MALFORMED;
        end
      end else if ((size_ph == PH_ZERO) && ((in_byte == CH_LC_X) || (in_byte == CH_UC_X))) begin
        phase_nxt = PH_X;
      end else if (((size_ph == PH_ZERO) || (size_ph == PH_X) || (size_ph == PH_DIGITS)) && hex)
      begin
        left_nxt  = add_digit(left_r, digit);
        phase_nxt = PH_DIGITS;
      end else if (in_byte == CH_CR) begin
        phase_nxt = PH_LINE_CR;
      end else if ((size_ph == PH_LINE_CR) && (in_byte == CH_LF)) begin
        neg_nxt = 1'b0;
        if (left_r == '0) begin
          phase_nxt  = PH_DONE;
          sticky_nxt = ST_TERMINATED;
        end else begin
          left_nxt  = neg_r ? '1 : left_r;
          phase_nxt = PH_DATA;
        end
      end else begin
        phase_nxt = PH_LINE;
      end
    end
  end

  always_comb begin : result_out
    unique case (phase_nxt)
      PH_SIGN: status = ST_MALFORMED;
      PH_DATA: status = ST_TRUNCATED;
      PH_DONE: status = sticky_nxt;
      default: status = ST_NO_ZERO;
    endcase
    res.out_byte   = emit ? in_byte : 8'd0;
    res.byte_valid = emit;
    res.body_end   = in_final;
    res.end_status = in_final ? status : ST_TERMINATED;
    has_res        = emit || in_final;
  end

  a_emit_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    res.byte_valid |-> (phase_r == PH_DATA))
    else $error("Payload byte produced outside chunk data.");

  a_data_owes_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (left_r != '0))
    else $error("Chunk data phase with nothing owed.");

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_final && (phase_r == PH_DONE)) |=> (phase_r == PH_DONE))
    else $error("Decoder left the stopped state before the final byte.");

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_final) |=> ((phase_r == PH_WS) && !neg_r && (left_r == '0)))
    else $error("State not cleared after the final byte.");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res.end_status != ST_TERMINATED) |-> res.body_end)
    else $error("End status given without end of body.");

endmodule

>>> sv/http_chunked_body_decoder.sv
// Channel   Direction  Payload                                          Transfer
// in_chan   sink       in_byte[7:0], in_final                           valid & ready
// out_chan  source     out_byte[7:0], byte_valid, body_end, end_status   valid & ready
//
// One byte is taken per cycle unless stalled; its result shows in the next cycle.
// The byte is decoded by a single combinational pass.
// Reset is synchronous and returns the decoder to the start of a body.
// A held result stalls the input only while the output side is not ready.
module http_chunked_body_decoder (
  input logic       clk,
  input logic       rst_n,
  hcbd_in_if.sink   in_chan,
  hcbd_out_if.source out_chan
);
  import hcbd_pkg::*;

  res_t res, res_r;
  logic has_res, accept, out_valid_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  hcbd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_chan.in_byte),
    .in_final (in_chan.in_final),
    .res      (res),
    .has_res  (has_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= has_res;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_byte   = res_r.out_byte;
  assign out_chan.byte_valid = res_r.byte_valid;
  assign out_chan.body_end   = res_r.body_end;
  assign out_chan.end_status = res_r.end_status;

endmodule

>>> dv/http_chunked_body_decoder_chk.sv
module http_chunked_body_decoder_chk (
  input  logic        clk,
  input  logic        rst_n,
  hcbd_in_if          in_mon,
  hcbd_out_if         out_mon,
  output int unsigned errors,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam size_t SIZE_ALL_ONES = '1;

  phase_t      ph;
  size_t       count;
  bit          minus;
  status_t     held_status;
  res_t        decoded_due[$];
  int unsigned fails = 0;
  int unsigned due_count = 0;

  assign errors      = fails;
  assign outstanding = due_count;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void restart_body();
    ph          = PH_WS;
    count       = '0;
    minus       = 1'b0;
    held_status = ST_TERMINATED;
  endfunction

  // Once another digit would overflow the counter, the size sticks at all ones.
  function automatic void shift_in(int d);
    logic [3:0] nib;
    nib = d[3:0];
    if (count > (SIZE_ALL_ONES >> 4)) begin
      count = SIZE_ALL_ONES;
    end else begin
      count = {count[HCBD_SIZE_BITS-5:0], nib};
    end
  endfunction

  function automatic void stop_decoding(status_t st);
    ph          = PH_DONE;
    held_status = st;
  endfunction

  function automatic void end_of_line(logic [7:0] c);
    size_t v;
    if (c == CH_CR) begin
      ph = PH_LINE_CR;
    end else if (ph == PH_LINE_CR && c == CH_LF) begin
      v = count;
      if (minus && v != '0) v = SIZE_ALL_ONES;
      minus = 1'b0;
      if (v == '0) begin
        count = '0;
        stop_decoding(ST_TERMINATED);
      end else begin
        count = v;
        ph    = PH_DATA;
      end
    end else begin
      ph = PH_LINE;
    end
  endfunction

  function automatic void size_char(logic [7:0] c);
    int d;
    d = hex_digit(c);
    case (ph)
      PH_WS: begin
        if (!blank(c)) begin
          count = '0;
          minus = 1'b0;
          if (c == CH_PLUS || c == CH_MINUS) begin
            minus = (c == CH_MINUS);
            ph    = PH_SIGN;
          end else if (c == CH_ZERO) begin
            ph = PH_ZERO;
          end else if (d >= 0) begin
            shift_in(d);
            ph = PH_DIGITS;
          end else begin
            stop_decoding(ST_MALFORMED);
          end
        end
      end
      PH_SIGN: begin
        if (c == CH_ZERO) begin
          ph = PH_ZERO;
        end else if (d >= 0) begin
          shift_in(d);
          ph = PH_DIGITS;
        end else begin
          stop_decoding(ST_MALFORMED);
        end
      end
      PH_ZERO: begin
        if (c == CH_LC_X || c == CH_UC_X) begin
          ph = PH_X;
        end else if (d >= 0) begin
          shift_in(d);
          ph = PH_DIGITS;
        end else begin
          end_of_line(c);
        end
      end
      PH_X, PH_DIGITS: begin
        if (d >= 0) begin
          shift_in(d);
          ph = PH_DIGITS;
        end else begin
          end_of_line(c);
        end
      end
      default: begin
        end_of_line(c);
      end
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] c, input logic fin,
                                      output bit emits, output res_t r);
    bit      payload;
    status_t st;
    payload = 1'b0;
    st      = ST_TERMINATED;
    case (ph)
      PH_DONE: begin
        payload = 1'b0;
      end
      PH_DATA: begin
        payload = 1'b1;
        count   = count - size_t'(1);
        if (count == '0) ph = PH_TRAIL;
      end
      PH_TRAIL: begin
        if (c == CH_CR) begin
          ph = PH_TRAIL_CR;
        end else begin
          ph = PH_WS;
          size_char(c);
        end
      end
      PH_TRAIL_CR: begin
        ph = PH_WS;
        if (c != CH_LF) size_char(c);
      end
      default: begin
        if (ph > PH_LINE_CR) ph = PH_WS;
        size_char(c);
      end
    endcase
    if (fin) begin
      case (ph)
        PH_SIGN: st = ST_MALFORMED;
        PH_DATA: st = ST_TRUNCATED;
        PH_DONE: st = held_status;
        default: st = ST_NO_ZERO;
      endcase
    end
    emits        = payload || fin;
    r.out_byte   = payload ? c : 8'h00;
    r.byte_valid = payload;
    r.body_end   = fin;
    r.end_status = fin ? st : ST_TERMINATED;
    if (fin) restart_body();
  endfunction

  function automatic void flag_field(string field, logic [7:0] want_v, logic [7:0] got_v);
    fails++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
  endfunction

  always @(posedge clk) begin : watch
    bit   emits;
    res_t want;
    res_t got;
    if (!rst_n) begin
      restart_body();
      decoded_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_byte(in_mon.in_byte, in_mon.in_final, emits, want);
        if (emits) decoded_due.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.out_byte   = out_mon.out_byte;
        got.byte_valid = out_mon.byte_valid;
        got.body_end   = out_mon.body_end;
        got.end_status = out_mon.end_status;
        if (decoded_due.size() == 0) begin
          fails++;
          $display("%0t ns: unexpected result transfer, expected none, actual %h",
                   $time, got);
        end else begin
          want = decoded_due.pop_front();
          if (got.out_byte !== want.out_byte)
            flag_field("out_byte", want.out_byte, got.out_byte);
          if (got.byte_valid !== want.byte_valid)
            flag_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
          if (got.body_end !== want.body_end)
            flag_field("body_end", 8'(want.body_end), 8'(got.body_end));
          if (got.end_status !== want.end_status)
            flag_field("end_status", 8'(want.end_status), 8'(got.end_status));
        end
      end
    end
    due_count = decoded_due.size();
  end

endmodule

>>> dv/http_chunked_body_decoder_tb.sv
module http_chunked_body_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned ITEMS_PER_PHASE = 175;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned phase_items;
  int unsigned mismatches;
  int unsigned outstanding;
  logic [7:0]  body_bytes[$];

  hcbd_in_if  in_chan ();
  hcbd_out_if out_chan ();

  http_chunked_body_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  http_chunked_body_decoder_chk decode_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .errors      (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // A long hold-off blocks the result channel while the sender keeps offering bytes.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic put(logic [7:0] b);
    body_bytes.push_back(b);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s.getc(i));
  endtask

  function automatic logic [7:0] hex_char(int unsigned v);
    if (v < 10) return 8'(CH_ZERO + v);
    return 8'(($urandom_range(1) ? CH_LC_A : CH_UC_A) + v - 10);
  endfunction

  task automatic put_size_line(int unsigned n);
    int unsigned digits;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(2, 1))
        put(($urandom_range(5) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
    end
    if ($urandom_range(99) < 10) begin
      put(CH_PLUS);
    end else if (n == 0 && $urandom_range(99) < 10) begin
      put(CH_MINUS);
    end
    if ($urandom_range(99) < 15) begin
      put(CH_ZERO);
      put($urandom_range(1) ? CH_LC_X : CH_UC_X);
    end
    if ($urandom_range(99) < 15) repeat ($urandom_range(2, 1)) put(CH_ZERO);
    digits = 1;
    while (digits < 8 && (n >> (4 * digits)) != 0) digits++;
    // A 0x prefix or leading zero followed by no digit reads as a zero size; a bare sign with no digit is malformed.
    if (n != 0 || $urandom_range(3) != 0) begin
      for (int k = digits; k > 0; k--) put(hex_char((n >> (4 * (k - 1))) & 15));
    end
    if ($urandom_range(99) < 15) begin
      put(CH_SEMI);
      repeat ($urandom_range(4, 1)) put(8'($urandom_range(8'h7E, 8'h20)));
    end
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic put_chunked_body(int unsigned chunks);
    int unsigned n;
    int unsigned pick;
    repeat (chunks) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      put_size_line(n);
      repeat (n) put(8'($urandom_range(255)));
      pick = $urandom_range(99);
      if (pick < 85) begin
        put(CH_CR);
        put(CH_LF);
      end else if (pick < 90) begin
        put(CH_CR);
      end else if (pick < 95) begin
        put(CH_LF);
      end
    end
    put_size_line(0);
    pick = $urandom_range(99);
    if (pick < 50) begin
      put(CH_CR);
      put(CH_LF);
    end else if (pick < 70) begin
      repeat ($urandom_range(3, 1)) put(8'($urandom_range(255)));
    end
  endtask

  task automatic build_random_body();
    int unsigned kind;
    int unsigned cut;
    body_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 85) begin
      put_chunked_body($urandom_range(3));
      if (kind >= 60 && kind < 75) begin
        cut = $urandom_range(body_bytes.size(), 1);
        while (body_bytes.size() > cut) void'(body_bytes.pop_back());
      end else if (kind >= 75) begin
        body_bytes[$urandom_range(body_bytes.size() - 1)] = 8'($urandom_range(255));
      end
    end else if (kind < 93) begin
      if ($urandom_range(1)) begin
        put(CH_MINUS);
        repeat ($urandom_range(3, 1)) put(hex_char($urandom_range(15, 1)));
      end else begin
        put(hex_char($urandom_range(15, 1)));
        repeat ($urandom_range(19, 15)) put(hex_char($urandom_range(15)));
      end
      put(CH_CR);
      put(CH_LF);
      repeat ($urandom_range(6, 1)) put(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(8, 1)) put(8'($urandom_range(255)));
    end
  endtask

  task automatic offer(logic [7:0] b, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.in_byte  <= b;
    in_chan.in_final <= fin;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic send_body();
    for (int i = 0; i < body_bytes.size(); i++) begin
      offer(body_bytes[i], i == body_bytes.size() - 1);
      phase_items++;
    end
    body_bytes.delete();
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    in_chan.valid    = 1'b0;
    in_chan.in_byte  = 8'h00;
    in_chan.in_final = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Payload at both byte extremes, a body cut off before any zero-size chunk.
    put_text("2\r\n");
    put(8'h00);
    put(8'hFF);
    send_body();
    // A bare prefix is a zero size and terminates.
    put_text("0x\r\n");
    send_body();
    // A bad first character stops decoding; the rest is ignored.
    put_text("gz");
    send_body();
    put_text("-");
    send_body();
    // A negative size counts as oversize, so the body ends truncated.
    put_text("-1\r\nA");
    send_body();
    put(8'hFF);
    send_body();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      phase_items = 0;
      if (ph == 0) begin
        holds_asked++;
        put_size_line(30);
        repeat (30) put(8'($urandom_range(255)));
        put_text("\r\n0\r\n");
        send_body();
      end
      while (phase_items < ITEMS_PER_PHASE) begin
        build_random_body();
        send_body();
      end
      drain();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
